@@ rtl/integer_to_radix_ascii_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_radix_ascii
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itra assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itra assertion failed");

`endif

@@ rtl/itra_pkg.sv @@
// ----------------------------------------------------------------------------
// itra_pkg
// Types, character constants and helper functions of the radix converter.
// ----------------------------------------------------------------------------
package itra_pkg;

	localparam int VALUE_WIDTH_DEFAULT = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic sign;
		logic digit;
	} itra_cmd_t;

	typedef struct packed {
		logic in_dec;
		logic in_neg;
		logic neg;
		logic cnt_one;
		logic out_free;
	} itra_sts_t;

	// Number of decimal digits of the largest magnitude, 2 to the power width-1.
	function automatic int dec_digits(int width);
		longint unsigned v;
		int n;
		v = 64'd1 << (width - 1);
		n = 0;
		while (v != 64'd0) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] d);
		if ({4'd0, d} <= (CHAR_NINE - CHAR_ZERO)) begin
			return CHAR_ZERO + {4'd0, d};
		end
		return CHAR_A + {4'd0, d} - 8'd10;
	endfunction

endpackage

@@ rtl/itra_in_if.sv @@
// ----------------------------------------------------------------------------
// itra_in_if
// Input channel: one signed number and its radix code per transaction.
// ----------------------------------------------------------------------------
interface itra_in_if #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEFAULT
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic [1:0]                    radix_code;

	modport source (output valid, output value, output radix_code, input ready);
	modport sink (input valid, input value, input radix_code, output ready);
endinterface

@@ rtl/itra_out_if.sv @@
// ----------------------------------------------------------------------------
// itra_out_if
// Output channel: one ASCII character and an end-of-text flag per transaction.
// ----------------------------------------------------------------------------
interface itra_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/integer_to_radix_ascii.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to ASCII text in radix 2, 8, 10 or 16.
// ----------------------------------------------------------------------------
// One number is taken per transaction and its text leaves as one character per
// transaction, most significant first, with a leading minus sign for negative
// values and last set on the final character. A binary, octal or hexadecimal
// number is loaded and then stepped through every digit slot of the full width
// (VALUE_WIDTH, ceil(VALUE_WIDTH/3) or ceil(VALUE_WIDTH/4)), leading zero slots
// being dropped silently, with a sign step first for a negative value. A decimal
// number first shifts all VALUE_WIDTH bits through the binary-to-BCD loop and
// then steps through each decimal digit slot (10 at the default width). No new
// number is taken until its text is done, and the output side stalls the sign
// and digit steps whenever its register is still full.
module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	itra_in_if.sink    number,
	itra_out_if.source text
);

	itra_pkg::itra_cmd_t cmd;
	itra_pkg::itra_sts_t sts;

	itra_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itra_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (number.value),
		.radix_code    (number.radix_code),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (text.ready),
		.out_valid     (text.valid),
		.out_character (text.character),
		.out_last      (text.last)
	);

`include "integer_to_radix_ascii_macros.svh"

	`ITRA_ASSERT_NEXT(a_busy_after_accept, number.valid && number.ready, !number.ready)
	`ITRA_ASSERT_SAME(a_sign_only_negative, cmd.sign, sts.neg && sts.out_free)
	`ITRA_ASSERT_NEXT(a_emit_sets_valid, cmd.sign, text.valid && !text.last)

endmodule

@@ rtl/itra_controller.sv @@
// ----------------------------------------------------------------------------
// itra_controller
// Sequencer: load, decimal conversion, sign and digit emission.
// ----------------------------------------------------------------------------
module itra_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  itra_pkg::itra_sts_t  sts,
	output itra_pkg::itra_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DABBLE = 4'b0010,
		ST_SIGN   = 4'b0100,
		ST_DIGITS = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.in_dec) begin
						state_d = ST_DABBLE;
					end else if (sts.in_neg) begin
						state_d = ST_SIGN;
					end else begin
						state_d = ST_DIGITS;
					end
				end
			end
			ST_DABBLE: begin
				if (sts.cnt_one) begin
					state_d = sts.neg ? ST_SIGN : ST_DIGITS;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (sts.out_free && sts.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.dabble = (state_q == ST_DABBLE);
	assign cmd.sign   = (state_q == ST_SIGN) && sts.out_free;
	assign cmd.digit  = (state_q == ST_DIGITS) && sts.out_free;

endmodule

@@ rtl/itra_datapath.sv @@
// ----------------------------------------------------------------------------
// itra_datapath
// Magnitude, digit shift register, binary-to-BCD step and output register.
// ----------------------------------------------------------------------------
module itra_datapath #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [1:0]                    radix_code,
	input  itra_pkg::itra_cmd_t           cmd,
	output itra_pkg::itra_sts_t           sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [7:0]                    out_character,
	output logic                          out_last
);

	localparam int W      = VALUE_WIDTH;
	localparam int ND_OCT = (W + 2) / 3;
	localparam int ND_HEX = (W + 3) / 4;
	localparam int NDEC   = itra_pkg::dec_digits(W);
	localparam int BW     = 4 * NDEC;
	localparam int SRW_A  = (BW > 4 * ND_HEX) ? BW : 4 * ND_HEX;
	localparam int SRW    = (SRW_A > 3 * ND_OCT) ? SRW_A : 3 * ND_OCT;
	localparam int CW     = $clog2(W + 1);

	logic [SRW-1:0]        sr_q;
	logic [W-1:0]          bin_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	itra_pkg::radix_t      radix_q;
	logic                  started_q;
	logic                  ovalid_q;
	logic [7:0]            ochar_q;
	logic                  olast_q;

	logic [W-1:0]          mag;
	logic [3:0]            digit;
	logic [SRW-1:0]        sr_shift;
	logic [SRW-1:0]        sr_dab;
	logic [BW-1:0]         bcd_adj;
	logic                  cnt_one;
	logic                  out_free;
	logic                  skip;
	logic                  emit_digit;

	assign mag = value[W-1] ? (~value + W'(1)) : value;

	always_comb begin
		case (radix_q)
			itra_pkg::RADIX_BIN: begin
				digit    = {3'd0, sr_q[SRW-1]};
				sr_shift = sr_q << 1;
			end
			itra_pkg::RADIX_OCT: begin
				digit    = {1'b0, sr_q[SRW-1 -: 3]};
				sr_shift = sr_q << 3;
			end
			default: begin
				digit    = sr_q[SRW-1 -: 4];
				sr_shift = sr_q << 4;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (sr_q[SRW-BW+4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = sr_q[SRW-BW+4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = sr_q[SRW-BW+4*i +: 4];
			end
		end
	end

	assign sr_dab     = SRW'({bcd_adj[BW-2:0], bin_q[W-1]}) << (SRW - BW);
	assign cnt_one    = (cnt_q == CW'(1));
	assign out_free   = !ovalid_q || out_ready;
	assign skip       = !started_q && (digit == 4'd0) && !cnt_one;
	assign emit_digit = cmd.digit && !skip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q  <= 1'b0;
			started_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cmd.sign || emit_digit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.load) begin
				started_q <= 1'b0;
				case (itra_pkg::radix_t'(radix_code))
					itra_pkg::RADIX_BIN: cnt_q <= CW'(W);
					itra_pkg::RADIX_OCT: cnt_q <= CW'(ND_OCT);
					itra_pkg::RADIX_DEC: cnt_q <= CW'(W);
					default:             cnt_q <= CW'(ND_HEX);
				endcase
			end else if (cmd.dabble) begin
				cnt_q <= cnt_one ? CW'(NDEC) : cnt_q - CW'(1);
			end else if (cmd.digit) begin
				cnt_q <= cnt_q - CW'(1);
				if (!skip) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q   <= value[W-1];
			radix_q <= itra_pkg::radix_t'(radix_code);
			bin_q   <= mag;
			case (itra_pkg::radix_t'(radix_code))
				itra_pkg::RADIX_BIN: sr_q <= SRW'(mag) << (SRW - W);
				itra_pkg::RADIX_OCT: sr_q <= SRW'(mag) << (SRW - 3 * ND_OCT);
				itra_pkg::RADIX_DEC: sr_q <= '0;
				default:             sr_q <= SRW'(mag) << (SRW - 4 * ND_HEX);
			endcase
		end else if (cmd.dabble) begin
			sr_q  <= sr_dab;
			bin_q <= bin_q << 1;
		end else if (cmd.digit) begin
			sr_q <= sr_shift;
		end
		if (cmd.sign) begin
			ochar_q <= itra_pkg::CHAR_MINUS;
			olast_q <= 1'b0;
		end else if (emit_digit) begin
			ochar_q <= itra_pkg::digit_char(digit);
			olast_q <= cnt_one;
		end
	end

	assign sts.in_dec   = (itra_pkg::radix_t'(radix_code) == itra_pkg::RADIX_DEC);
	assign sts.in_neg   = value[W-1];
	assign sts.neg      = neg_q;
	assign sts.cnt_one  = cnt_one;
	assign sts.out_free = out_free;

	assign out_valid     = ovalid_q;
	assign out_character = ochar_q;
	assign out_last      = olast_q;

endmodule
